// File: hdl/rcpc_pkg.sv
// Shared types and constants for the RC PWM capture and calibration block.
`timescale 1ns / 1ps
`default_nettype none

package rcpc_pkg;

    // Calibration register file
    localparam int CAL_W       = 36;
    localparam int CAL_FIELD_W = 12;
    localparam int NUM_CAL     = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CAL_W-1:0] CAL_RESET [NUM_CAL] = '{
        36'd32218350636, 36'd32218350636, 36'd32017024044,
        36'd32084149288, 36'd32151258156, 36'd26748978572
    };

    // Calibration of a channel that has no register
    localparam logic [CAL_FIELD_W-1:0] DEF_MIN = 12'd1000;
    localparam logic [CAL_FIELD_W-1:0] DEF_MID = 12'd1500;
    localparam logic [CAL_FIELD_W-1:0] DEF_MAX = 12'd2000;

    // Pin and item fields
    localparam int PIN_COUNT = 6;
    localparam int TIME_W    = 32;
    localparam int OUT_PW_W  = 16;
    localparam int POS_W     = 11;
    localparam int POS_SCALE = 1000;
    localparam int SCALE_W   = 10;
    localparam int QUO_W     = 11;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_FRAME  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_LOAD  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    typedef struct packed {
        logic [CAL_FIELD_W-1:0] mx;
        logic [CAL_FIELD_W-1:0] md;
        logic [CAL_FIELD_W-1:0] mn;
    } cal_t;

    typedef struct packed {
        logic sweep;
        logic clr_fresh;
        logic clr_frame;
    } cap_ctrl_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

`default_nettype wire

// File: hdl/rcpc_cal.sv
// Calibration register file with per-channel entry selection.
`timescale 1ns / 1ps
`default_nettype none

module rcpc_cal #(
    parameter int CHANNELS = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [rcpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rcpc_pkg::CAL_W-1:0]            cfg_data,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] idx,
    output rcpc_pkg::cal_t                             cal
);

    logic [rcpc_pkg::CAL_W-1:0]     cal_reg [rcpc_pkg::NUM_CAL];
    logic [rcpc_pkg::CFG_IDX_W-1:0] sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rcpc_pkg::NUM_CAL; i++)
            begin
                cal_reg[i] <= rcpc_pkg::CAL_RESET[i];
            end
        end
        else if (cfg_write && (cfg_index < rcpc_pkg::CFG_IDX_W'(rcpc_pkg::NUM_CAL)))
        begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    assign sel = rcpc_pkg::CFG_IDX_W'(idx);

    // Channels past the register file fall back to the default calibration
    always_comb
    begin
        if (sel < rcpc_pkg::CFG_IDX_W'(rcpc_pkg::NUM_CAL))
        begin
            cal = cal_reg[sel];
        end
        else
        begin
            cal.mn = rcpc_pkg::DEF_MIN;
            cal.md = rcpc_pkg::DEF_MID;
            cal.mx = rcpc_pkg::DEF_MAX;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rcpc_capture.sv
// Per-channel edge capture stores, swept one channel per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rcpc_capture #(
    parameter int CHANNELS   = 6,
    parameter int WIDTH_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rcpc_pkg::cap_ctrl_t                   ctrl,
    input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] idx,
    input  wire logic [rcpc_pkg::PIN_COUNT-1:0]        pins,
    input  wire logic [rcpc_pkg::TIME_W-1:0]           time_now,
    output logic      [rcpc_pkg::TIME_W-1:0]           rise,
    output logic      [WIDTH_BITS-1:0]                 width,
    output logic      [rcpc_pkg::TIME_W-1:0]           period,
    output logic                                       fresh,
    output logic                                       frame
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [rcpc_pkg::TIME_W:0] WMAX =
        (33'd1 << WIDTH_BITS) - 33'd1;

    logic [CHANNELS-1:0]            level_reg;
    logic [CHANNELS-1:0]            fresh_reg;
    logic                           frame_reg;
    logic [rcpc_pkg::TIME_W-1:0]    rise_reg   [CHANNELS];
    logic [WIDTH_BITS-1:0]          width_reg  [CHANNELS];
    logic [rcpc_pkg::TIME_W-1:0]    period_reg [CHANNELS];

    logic [CHANNELS-1:0]            lvl_vec;
    logic                           lvl;
    logic [rcpc_pkg::TIME_W-1:0]    diff;
    logic [WIDTH_BITS-1:0]          width_sat;

    // Channels without a pin read low
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (i < rcpc_pkg::PIN_COUNT)
            begin
                lvl_vec[i] = pins[i % rcpc_pkg::PIN_COUNT];
            end
            else
            begin
                lvl_vec[i] = 1'b0;
            end
        end
    end

    assign lvl       = lvl_vec[idx];
    assign diff      = time_now - rise_reg[idx];
    assign width_sat = ({1'b0, diff} > WMAX) ? '1 : diff[WIDTH_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            fresh_reg <= '0;
            frame_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rise_reg[i]   <= '0;
                width_reg[i]  <= '0;
                period_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.sweep)
            begin
                if (!level_reg[idx] && lvl)
                begin
                    level_reg[idx]  <= 1'b1;
                    period_reg[idx] <= diff;
                    rise_reg[idx]   <= time_now;
                end
                else if (level_reg[idx] && !lvl)
                begin
                    level_reg[idx] <= 1'b0;
                    width_reg[idx] <= width_sat;
                    fresh_reg[idx] <= 1'b1;
                    if (idx == IDX_W'(CHANNELS - 1))
                    begin
                        frame_reg <= 1'b1;
                    end
                end
            end
            if (ctrl.clr_fresh)
            begin
                fresh_reg[idx] <= 1'b0;
            end
            if (ctrl.clr_frame)
            begin
                frame_reg <= 1'b0;
            end
        end
    end

    assign rise   = rise_reg[idx];
    assign width  = width_reg[idx];
    assign period = period_reg[idx];
    assign fresh  = fresh_reg[idx];
    assign frame  = frame_reg;

endmodule

`default_nettype wire

// File: hdl/rcpc_divider.sv
// Bit-serial restoring divider with a quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module rcpc_divider #(
    parameter int NUM_W = 26
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [NUM_W-1:0]                    dividend,
    input  wire logic [rcpc_pkg::CAL_FIELD_W-1:0]    divisor,
    output rcpc_pkg::div_res_t                       res
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int DS_W  = rcpc_pkg::CAL_FIELD_W;

    logic                           busy_reg;
    logic                           done_reg;
    logic                           ovf_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [NUM_W-1:0]               dvd_reg;
    logic [DS_W-1:0]                dsr_reg;
    logic [DS_W-1:0]                rem_reg;
    logic [rcpc_pkg::QUO_W-1:0]     quo_reg;

    logic [DS_W:0]                  trial;
    logic                           ge;
    logic [DS_W:0]                  trial_sub;

    // Bring down one dividend bit and try the subtract
    assign trial     = {rem_reg, dvd_reg[NUM_W-1]};
    assign ge        = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? trial_sub[DS_W-1:0] : trial[DS_W-1:0];
            // Any bit pushed off the top means the quotient is out of range
            quo_reg <= {quo_reg[rcpc_pkg::QUO_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[rcpc_pkg::QUO_W-1];
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

`default_nettype wire

// File: hdl/rc_pwm_capture_calibrate_top.sv
// Top level of the six-channel RC PWM capture with calibrated stick position.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------
//  in      | in_valid/in_ready, operation, pin_levels,| sample, read or frame take
//          | time_us, channel                         |
//  out     | out_valid/out_ready, available, ...      | one result beat per item
//  cfg     | cfg_write, cfg_index, cfg_data           | calibration writes
//
// During a sample the channel stores are swept one channel per cycle.
// A read with a live measurement runs the bit-serial divider (WIDTH_BITS + 10 steps),
// unless its position is zero outright; other items skip the divider.
// One item is in work at a time; the next is taken while a result beat waits on out_ready.
// Reset clears all capture state and loads the default calibration.
`timescale 1ns / 1ps
`default_nettype none

module rc_pwm_capture_calibrate_top #(
    parameter int CHANNELS   = 6,
    parameter int WIDTH_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          operation,
    input  wire logic [rcpc_pkg::PIN_COUNT-1:0]      pin_levels,
    input  wire logic [rcpc_pkg::TIME_W-1:0]         time_us,
    input  wire logic [2:0]                          channel,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     available,
    output logic      [rcpc_pkg::TIME_W-1:0]         rise_time,
    output logic      [rcpc_pkg::OUT_PW_W-1:0]       pulse_width,
    output logic      [rcpc_pkg::TIME_W-1:0]         pulse_period,
    output logic signed [rcpc_pkg::POS_W-1:0]        position,
    output logic                                     frame_ready,
    input  wire logic                                cfg_write,
    input  wire logic [rcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rcpc_pkg::CAL_W-1:0]          cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NUM_W = WIDTH_BITS + rcpc_pkg::SCALE_W;
    localparam int FW    = rcpc_pkg::CAL_FIELD_W;
    localparam int PW    = rcpc_pkg::POS_W;
    localparam logic signed [FW:0]   POS_HI  = 13'sd1000;
    localparam logic signed [FW:0]   POS_LO  = -13'sd1000;
    localparam logic signed [PW-1:0] POS_MAX = 11'sd1000;
    localparam logic signed [PW-1:0] POS_MIN = -11'sd1000;

    rcpc_pkg::state_t               state_reg;
    rcpc_pkg::state_t               state_next;
    logic [IDX_W-1:0]               idx_reg;
    logic [IDX_W-1:0]               idx_next;

    logic [rcpc_pkg::PIN_COUNT-1:0] pins_reg;
    logic [rcpc_pkg::TIME_W-1:0]    time_reg;

    logic                           res_avail_reg;
    logic [rcpc_pkg::TIME_W-1:0]    res_rise_reg;
    logic [rcpc_pkg::OUT_PW_W-1:0]  res_width_reg;
    logic [rcpc_pkg::TIME_W-1:0]    res_period_reg;
    logic signed [PW-1:0]           res_pos_reg;
    logic                           res_frame_reg;

    logic [WIDTH_BITS-1:0]          mag_reg;
    logic [FW-1:0]                  span_reg;
    logic                           neg_reg;
    logic                           lower_reg;

    logic                           out_valid_reg;
    logic                           available_reg;
    logic [rcpc_pkg::TIME_W-1:0]    rise_time_reg;
    logic [rcpc_pkg::OUT_PW_W-1:0]  pulse_width_reg;
    logic [rcpc_pkg::TIME_W-1:0]    pulse_period_reg;
    logic signed [PW-1:0]           position_reg;
    logic                           frame_ready_reg;

    logic                           accept;
    logic                           out_load;
    logic                           chan_ok;
    logic [IDX_W-1:0]               chan_idx;
    rcpc_pkg::cap_ctrl_t            cap_ctrl;
    rcpc_pkg::cal_t                 cal;
    rcpc_pkg::div_res_t             div_res;
    logic                           div_start;
    logic [NUM_W-1:0]               product;

    logic [rcpc_pkg::TIME_W-1:0]    cap_rise;
    logic [WIDTH_BITS-1:0]          cap_width;
    logic [rcpc_pkg::TIME_W-1:0]    cap_period;
    logic                           cap_fresh;
    logic                           cap_frame;

    logic                           upper;
    logic [FW-1:0]                  seg_lo;
    logic [FW-1:0]                  seg_hi;
    logic [WIDTH_BITS:0]            diff;
    logic [WIDTH_BITS-1:0]          diff_mag;
    logic [FW:0]                    span;
    logic [FW-1:0]                  span_mag;
    logic                           pos_zero;

    logic [rcpc_pkg::QUO_W-1:0]     q_sat;
    logic signed [FW:0]             q_signed;
    logic signed [FW:0]             pos_raw;
    logic signed [PW-1:0]           pos_clamped;

    assign in_ready = (state_reg == rcpc_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == rcpc_pkg::S_FIN) && (!out_valid_reg || out_ready);
    assign chan_ok  = (channel != 3'd0) && (4'(channel) <= 4'(CHANNELS));
    assign chan_idx = IDX_W'(channel - 3'd1);

    rcpc_cal #(
        .CHANNELS (CHANNELS)
    ) u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .idx       (idx_reg),
        .cal       (cal)
    );

    rcpc_capture #(
        .CHANNELS   (CHANNELS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_capture (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cap_ctrl),
        .idx      (idx_reg),
        .pins     (pins_reg),
        .time_now (time_reg),
        .rise     (cap_rise),
        .width    (cap_width),
        .period   (cap_period),
        .fresh    (cap_fresh),
        .frame    (cap_frame)
    );

    rcpc_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .res      (div_res)
    );

    // Pick the segment of the piecewise map and form signed offsets
    assign upper    = cap_width >= WIDTH_BITS'(cal.md);
    assign seg_lo   = upper ? cal.md : cal.mn;
    assign seg_hi   = upper ? cal.mx : cal.md;
    assign diff     = {1'b0, cap_width} - {1'b0, WIDTH_BITS'(seg_lo)};
    assign diff_mag = diff[WIDTH_BITS] ? WIDTH_BITS'(-diff) : diff[WIDTH_BITS-1:0];
    assign span     = {1'b0, seg_hi} - {1'b0, seg_lo};
    assign span_mag = span[FW] ? FW'(-span) : span[FW-1:0];
    assign pos_zero = (span == '0) || (!upper && (cap_width == '0));

    assign product  = NUM_W'(mag_reg) * NUM_W'(rcpc_pkg::POS_SCALE);

    // A quotient past 2047 clamps the same way as its true value
    assign q_sat    = div_res.ovf ? '1 : div_res.quo;
    assign q_signed = neg_reg ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    assign pos_raw  = q_signed + (lower_reg ? POS_LO : '0);

    always_comb
    begin
        if (pos_raw > POS_HI)
        begin
            pos_clamped = POS_MAX;
        end
        else if (pos_raw < POS_LO)
        begin
            pos_clamped = POS_MIN;
        end
        else
        begin
            pos_clamped = pos_raw[PW-1:0];
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        cap_ctrl.sweep     = 1'b0;
        cap_ctrl.clr_fresh = 1'b0;
        cap_ctrl.clr_frame = 1'b0;
        div_start          = 1'b0;
        unique case (state_reg)
            rcpc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (rcpc_pkg::op_t'(operation))
                        rcpc_pkg::OP_SAMPLE:
                        begin
                            idx_next   = '0;
                            state_next = rcpc_pkg::S_SWEEP;
                        end
                        rcpc_pkg::OP_READ:
                        begin
                            if (chan_ok)
                            begin
                                idx_next   = chan_idx;
                                state_next = rcpc_pkg::S_LOAD;
                            end
                            else
                            begin
                                state_next = rcpc_pkg::S_FIN;
                            end
                        end
                        rcpc_pkg::OP_FRAME:
                        begin
                            cap_ctrl.clr_frame = 1'b1;
                            state_next         = rcpc_pkg::S_FIN;
                        end
                        default:
                        begin
                            state_next = rcpc_pkg::S_FIN;
                        end
                    endcase
                end
            end
            rcpc_pkg::S_SWEEP:
            begin
                cap_ctrl.sweep = 1'b1;
                if (idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    state_next = rcpc_pkg::S_FIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            rcpc_pkg::S_LOAD:
            begin
                if (cap_fresh)
                begin
                    cap_ctrl.clr_fresh = 1'b1;
                    state_next = pos_zero ? rcpc_pkg::S_FIN : rcpc_pkg::S_MUL;
                end
                else
                begin
                    state_next = rcpc_pkg::S_FIN;
                end
            end
            rcpc_pkg::S_MUL:
            begin
                div_start  = 1'b1;
                state_next = rcpc_pkg::S_DIV;
            end
            rcpc_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = rcpc_pkg::S_FIN;
                end
            end
            rcpc_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = rcpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rcpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcpc_pkg::S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result build-up for the item in work
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_reg       <= pin_levels;
            time_reg       <= time_us;
            res_avail_reg  <= 1'b0;
            res_rise_reg   <= '0;
            res_width_reg  <= '0;
            res_period_reg <= '0;
            res_pos_reg    <= '0;
            res_frame_reg  <= (rcpc_pkg::op_t'(operation) == rcpc_pkg::OP_FRAME) && cap_frame;
        end
        if ((state_reg == rcpc_pkg::S_LOAD) && cap_fresh)
        begin
            res_avail_reg  <= 1'b1;
            res_rise_reg   <= cap_rise;
            res_width_reg  <= rcpc_pkg::OUT_PW_W'(cap_width);
            res_period_reg <= cap_period;
            mag_reg        <= diff_mag;
            span_reg       <= span_mag;
            neg_reg        <= diff[WIDTH_BITS] ^ span[FW];
            lower_reg      <= !upper;
        end
        if ((state_reg == rcpc_pkg::S_DIV) && div_res.done)
        begin
            res_pos_reg <= pos_clamped;
        end
        if (out_load)
        begin
            available_reg    <= res_avail_reg;
            rise_time_reg    <= res_rise_reg;
            pulse_width_reg  <= res_width_reg;
            pulse_period_reg <= res_period_reg;
            position_reg     <= res_pos_reg;
            frame_ready_reg  <= res_frame_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign available    = available_reg;
    assign rise_time    = rise_time_reg;
    assign pulse_width  = pulse_width_reg;
    assign pulse_period = pulse_period_reg;
    assign position     = position_reg;
    assign frame_ready  = frame_ready_reg;

    // The divider only finishes while a read waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == rcpc_pkg::S_DIV))
        else $error("divider finished outside a read");

    // An accepted sample starts the channel sweep at channel zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == rcpc_pkg::OP_SAMPLE))
        |=> ((state_reg == rcpc_pkg::S_SWEEP) && (idx_reg == '0)))
        else $error("sample did not start the sweep");

    // A delivered position stays within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((position_reg <= POS_MAX) && (position_reg >= POS_MIN)))
        else $error("position out of range");

    // A result beat never carries both a measurement and the frame flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && available_reg) |-> !frame_ready_reg)
        else $error("measurement and frame flag in one beat");

    // A read with a live measurement clears that channel's flag as it loads
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rcpc_pkg::S_LOAD) && cap_fresh) |=> !cap_fresh)
        else $error("new-value flag not cleared on read");

endmodule

`default_nettype wire
